// ===== hdl/bdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Operation and status codes, payload widths and the control bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int VALUE_W = 32;
	localparam int OCC_W   = 5;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
		logic rej_full;
		logic rej_empty;
		logic load_pop;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} flags_t;

endpackage
`default_nettype wire

// ===== hdl/bdq_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_req_if: request channel of the bounded deque
// One word carries an operation code and the value to push.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	logic                                  valid;
	logic                                  ready;
	bdq_pkg::op_t                          kind;
	logic signed [bdq_pkg::VALUE_W-1:0]    value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/bdq_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_rsp_if: response channel of the bounded deque
// One word carries the popped value, a status code and the occupancy.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bdq_pkg::VALUE_W-1:0]    popped;
	bdq_pkg::status_t                      status;
	logic [bdq_pkg::OCC_W-1:0]             occupancy;

	modport source (output valid, output popped, output status, output occupancy,
		input ready);
	modport sink (input valid, input popped, input status, input occupancy,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/bdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl: controller of the bounded deque
// Decodes each request word, sequences the store read of a pop and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire bdq_pkg::op_t    req_kind,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire bdq_pkg::flags_t flags,
	output bdq_pkg::cmd_t        cmd
);
	import bdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   load;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_kind)
						OP_PUSH_FRONT: begin
							cmd.rej_full   = flags.full;
							cmd.push_front = !flags.full;
						end
						OP_PUSH_REAR: begin
							cmd.rej_full  = flags.full;
							cmd.push_rear = !flags.full;
						end
						OP_POP_FRONT: begin
							cmd.rej_empty = flags.empty;
							cmd.pop_front = !flags.empty;
						end
						OP_POP_REAR: begin
							cmd.rej_empty = flags.empty;
							cmd.pop_rear  = !flags.empty;
						end
						default: begin
							cmd = '0;
						end
					endcase
					if (cmd.pop_front || cmd.pop_rear) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				// read data is registered: capture it now
				cmd.load_pop = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load = cmd.push_front || cmd.push_rear || cmd.rej_full ||
		cmd.rej_empty || cmd.load_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bdq_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dpath: datapath of the bounded deque
// Ring store, front pointer, element count and the response word register.
// ----------------------------------------------------------------------------
module bdq_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bdq_pkg::cmd_t                   cmd,
	input  wire logic signed [bdq_pkg::VALUE_W-1:0] value,
	output bdq_pkg::flags_t                      flags,
	output logic signed [bdq_pkg::VALUE_W-1:0]   popped,
	output bdq_pkg::status_t                     status,
	output logic [bdq_pkg::OCC_W-1:0]            occupancy
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(2 * DEPTH);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	logic [AW-1:0] front_q;
	logic [CW-1:0] held_q;

	logic [AW-1:0] front_dec, front_inc;
	logic [SW-1:0] rear_sum, rear_last_sum;
	logic [SW-1:0] rear_wrap, rear_last_wrap;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en, rd_en;

	logic signed [VALUE_W-1:0] popped_q;
	status_t                   status_q;
	logic [OCC_W-1:0]          occ_q;

	assign flags.full  = (held_q == CW'(DEPTH));
	assign flags.empty = (held_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// front + held stays below twice the depth: one conditional subtract wraps it
	assign rear_sum       = SW'(front_q) + SW'(held_q);
	assign rear_last_sum  = rear_sum - SW'(1);
	assign rear_wrap      = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
	assign rear_last_wrap = (rear_last_sum >= SW'(DEPTH)) ?
		rear_last_sum - SW'(DEPTH) : rear_last_sum;

	assign wr_en   = cmd.push_front || cmd.push_rear;
	assign rd_en   = cmd.pop_front || cmd.pop_rear;
	assign wr_addr = cmd.push_front ? front_dec : rear_wrap[AW-1:0];
	assign rd_addr = cmd.pop_front ? front_q : rear_last_wrap[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			held_q  <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (wr_en) begin
				held_q <= held_q + CW'(1);
			end else if (rd_en) begin
				held_q <= held_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			popped_q <= '0;
			status_q <= ST_DONE;
			occ_q    <= OCC_W'(held_q + CW'(1));
		end else if (cmd.rej_full) begin
			popped_q <= '0;
			status_q <= ST_FULL;
			occ_q    <= OCC_W'(held_q);
		end else if (cmd.rej_empty) begin
			popped_q <= '0;
			status_q <= ST_EMPTY;
			occ_q    <= OCC_W'(held_q);
		end else if (cmd.load_pop) begin
			// count was already decremented when the read was issued
			popped_q <= rd_data_q;
			status_q <= ST_DONE;
			occ_q    <= OCC_W'(held_q);
		end
	end

	assign popped    = popped_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule
`default_nettype wire

// ===== hdl/bounded_deque.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue of signed 32-bit words
// Ring store of DEPTH entries with a controller and a datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per word: push front, push rear, pop front or
//   pop rear, with the value to push. rsp returns exactly one word for each
//   request: the popped value (zero otherwise), a status (done, pop on empty,
//   push on full) and the number of words held afterwards.
//   A push or a refused operation shows its response in the cycle after
//   acceptance; a successful pop first passes through the registered read of
//   the ring store and then through the response register.
//   Throughput: one push per cycle while rsp is drained each cycle; a pop
//   blocks further requests while its store read is in progress.
//   req.ready is high when the controller is idle and the response register
//   is empty or being taken in the same cycle. A stalled rsp holds its word
//   and blocks further requests until it is taken.
//   Reset (arst_n low) empties the queue and drops any pending response; the
//   store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_deque #(
	parameter int DEPTH = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);
	import bdq_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	bdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (req.value),
		.flags     (flags),
		.popped    (rsp.popped),
		.status    (rsp.status),
		.occupancy (rsp.occupancy)
	);

endmodule
`default_nettype wire

// ===== hdl/bdq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_checker: port-level checks of the bounded deque
// Watches the response channel and checks status against popped value and
// occupancy.
// ----------------------------------------------------------------------------
module bdq_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [bdq_pkg::VALUE_W-1:0]   rsp_popped,
	input wire bdq_pkg::status_t              rsp_status,
	input wire logic [bdq_pkg::OCC_W-1:0]     rsp_occupancy
);
	import bdq_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped) &&
		$stable(rsp_status) && $stable(rsp_occupancy))
		else $error("response changed while stalled");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_DONE |-> rsp_popped == '0)
		else $error("refused operation returned a nonzero word");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OCC_W'(DEPTH))
		else $error("full status with wrong occupancy");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
		else $error("empty status with nonzero occupancy");

endmodule

bind bounded_deque bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_popped    (rsp.popped),
	.rsp_status    (rsp.status),
	.rsp_occupancy (rsp.occupancy)
);
`default_nettype wire

// ===== bench/bounded_deque_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_test: self-checking bench for the bounded deque
// A driver feeds push and pop words from a pending queue with random gaps. A
// monitor takes responses with random stalls. Each response is checked
// field by field against a ring-store predictor run at request acceptance.
// ----------------------------------------------------------------------------
module bounded_deque_test;
	import bdq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_OPS = 1000;

	typedef struct {
		op_t                      kind;
		logic signed [VALUE_W-1:0] word;
		int unsigned              gap;
		bit                       drain;
	} request_t;

	typedef struct {
		logic signed [VALUE_W-1:0] popped;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} outcome_t;

	logic clk;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque #(.DEPTH(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: ring store, index of the front word, word count
	logic signed [VALUE_W-1:0] ring [DEPTH];
	int head_pos;
	int held_cnt;

	request_t pending [$];
	outcome_t outcomes_due [$];

	int n_faults;
	int n_pushes, n_pops, n_full, n_empty, n_wraps;
	int n_sent, n_taken;
	int unsigned gap_count;
	int unsigned stall_left, stall_draw, calm_left;
	logic req_fire;
	request_t next_req;
	outcome_t want;

	task automatic note_fault(input string msg);
		n_faults++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic outcome_t deque_apply(input op_t op, input logic signed [VALUE_W-1:0] word);
		outcome_t res;
		int slot;
		res.popped = '0;
		res.status = ST_DONE;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (held_cnt >= DEPTH) begin
				res.status = ST_FULL;
				n_full++;
			end else if (op == OP_PUSH_FRONT) begin
				head_pos = (head_pos + DEPTH - 1) % DEPTH;
				ring[head_pos] = word;
				held_cnt++;
				n_pushes++;
			end else begin
				slot = (head_pos + held_cnt) % DEPTH;
				if (slot < head_pos)
					n_wraps++;
				ring[slot] = word;
				held_cnt++;
				n_pushes++;
			end
		end else begin
			if (held_cnt == 0) begin
				res.status = ST_EMPTY;
				n_empty++;
			end else if (op == OP_POP_FRONT) begin
				res.popped = ring[head_pos];
				head_pos = (head_pos + 1) % DEPTH;
				held_cnt--;
				n_pops++;
			end else begin
				res.popped = ring[(head_pos + held_cnt - 1) % DEPTH];
				held_cnt--;
				n_pops++;
			end
		end
		res.occupancy = OCC_W'(held_cnt);
		return res;
	endfunction

	function automatic logic signed [VALUE_W-1:0] draw_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_request(input op_t op, input logic signed [VALUE_W-1:0] word,
		input int unsigned gap, input bit drain);
		request_t r;
		r.kind = op;
		r.word = word;
		r.gap = gap;
		r.drain = drain;
		pending.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = OP_PUSH_FRONT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (11) @(posedge clk);
				arst_n <= 1'b1;
			end
		join
	end

	// driver: predict on acceptance, then present the next pending word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= OP_PUSH_FRONT;
			req_ch.value <= '0;
			gap_count <= 0;
			n_sent <= 0;
		end else begin
			req_fire = req_ch.valid && req_ch.ready;
			if (req_fire) begin
				outcomes_due.push_back(deque_apply(req_ch.kind, req_ch.value));
				n_sent <= n_sent + 1;
			end
			if (!req_ch.valid || req_fire) begin
				if (pending.size() == 0 ||
						(pending[0].drain && (req_fire || n_sent != n_taken))) begin
					req_ch.valid <= 1'b0;
				end else if (gap_count < pending[0].gap) begin
					req_ch.valid <= 1'b0;
					gap_count <= gap_count + 1;
				end else begin
					next_req = pending.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind <= next_req.kind;
					req_ch.value <= next_req.word;
					gap_count <= 0;
				end
			end
		end
	end

	// monitor: check each taken response, then draw the stall before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
			n_taken <= 0;
			calm_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_taken <= n_taken + 1;
				if (outcomes_due.size() == 0) begin
					note_fault("response word with nothing expected");
				end else begin
					want = outcomes_due.pop_front();
					if (rsp_ch.popped !== want.popped)
						note_fault($sformatf("popped %0d, expected %0d",
							rsp_ch.popped, want.popped));
					if (rsp_ch.status !== want.status)
						note_fault($sformatf("status %0d, expected %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.occupancy !== want.occupancy)
						note_fault($sformatf("occupancy %0d, expected %0d",
							rsp_ch.occupancy, want.occupancy));
				end
				if (calm_left > 0) begin
					calm_left--;
					stall_draw = 0;
				end else begin
					stall_draw = $urandom_range(0, 6);
					if ($urandom_range(0, 7) == 0)
						calm_left = $urandom_range(10, 40);
				end
				rsp_ch.ready <= (stall_draw == 0);
				stall_left <= stall_draw;
			end else if (!rsp_ch.ready) begin
				rsp_ch.ready <= (stall_left <= 1);
				if (stall_left > 0)
					stall_left <= stall_left - 1;
			end
		end
	end

	initial begin
		int total;
		int seg_len;
		int bias;
		int roll;
		bit calm;
		bit push;
		op_t op;

		n_faults = 0;
		n_pushes = 0;
		n_pops = 0;
		n_full = 0;
		n_empty = 0;
		n_wraps = 0;
		head_pos = 0;
		held_cnt = 0;

		// refused pops, extreme words from both ends
		add_request(OP_POP_FRONT, draw_word(), 0, 1'b0);
		add_request(OP_POP_REAR, draw_word(), 0, 1'b0);
		add_request(OP_PUSH_FRONT, 32'sh7fff_ffff, 0, 1'b0);
		add_request(OP_PUSH_REAR, 32'sh8000_0000, 1, 1'b0);
		add_request(OP_POP_REAR, draw_word(), 0, 1'b0);
		add_request(OP_POP_FRONT, draw_word(), 0, 1'b0);
		// fill from both ends so the front index wraps, then refuse pushes
		for (int i = 0; i < DEPTH; i++)
			add_request((i % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, draw_word(), 0, 1'b0);
		add_request(OP_PUSH_REAR, draw_word(), 0, 1'b0);
		add_request(OP_PUSH_FRONT, draw_word(), 2, 1'b0);
		add_request(OP_POP_FRONT, draw_word(), 0, 1'b0);
		add_request(OP_POP_REAR, draw_word(), 0, 1'b0);

		// random runs biased toward filling, draining or balance
		total = 0;
		while (total < RANDOM_OPS) begin
			seg_len = $urandom_range(8, 48);
			bias = $urandom_range(0, 2);
			calm = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < seg_len; j++) begin
				roll = $urandom_range(0, 9);
				case (bias)
					0: push = (roll < 8);
					1: push = (roll < 2);
					default: push = (roll < 5);
				endcase
				if (push)
					op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
				add_request(op, draw_word(), calm ? 0 : $urandom_range(0, 6),
					(total == 0) || (total == RANDOM_OPS / 2) ||
					(j == 0 && $urandom_range(0, 9) == 0));
				total++;
			end
		end

		while (pending.size() != 0 || req_ch.valid || n_sent != n_taken)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (outcomes_due.size() != 0)
			note_fault($sformatf("%0d responses never arrived", outcomes_due.size()));

		$display("covered %0d words: %0d pushes, %0d pops, %0d refused on full, %0d on empty",
			n_sent, n_pushes, n_pops, n_full, n_empty);
		$display("rear pushes across the ring end: %0d, mismatches: %0d", n_wraps, n_faults);
		if (n_faults == 0)
			$display("bounded_deque test passed");
		else
			$display("bounded_deque test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("bounded_deque test failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== bounded_deque.f =====
hdl/bdq_pkg.sv
hdl/bdq_req_if.sv
hdl/bdq_rsp_if.sv
hdl/bdq_ctrl.sv
hdl/bdq_dpath.sv
hdl/bounded_deque.sv
hdl/bdq_checker.sv
bench/bounded_deque_test.sv
